// ----- hdl/hvd_pkg.sv -----
// ---------------------------------------------------------------------------
// hvd_pkg
// Shared constants and elaboration-time helpers for the great circle
// distance pipeline: CORDIC arctangent entries, gain, radius scale.
// ---------------------------------------------------------------------------
package hvd_pkg;

	// pi in Q60
	localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

	// CORDIC gain constant in Q30
	localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;

	// 1.0 in Q30
	localparam logic [30:0] ONE_Q30 = 31'd1073741824;

	// 4 * radius * pi * 2^17, rounded
	localparam logic [63:0] KD = ((PI_Q60 >> 20) * 64'd25484 + 64'd4194304) >> 23;
	localparam logic [16:0] KD_LO = KD[16:0];
	localparam logic [16:0] KD_HI = KD[33:17];

	// floor(2^32 / 45) for the reciprocal divide
	localparam logic [26:0] RECIP45 = 27'd95443717;

	// one result bit per step of the square root
	localparam int SQRT_STEPS = 31;

	// Long division used only at elaboration time
	function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
		logic [63:0] q;
		logic [63:0] r;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[62:0], n[b]};
			if (r >= d) begin
				r = r - d;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// atan(2^-i) in binary turns, 2^32 per turn, from a truncated series
	function automatic logic [31:0] atan_entry(input int i);
		logic [63:0] two_pi;
		logic [63:0] acc;
		logic [63:0] term;
		int span;
		two_pi = (PI_Q60 + 64'd268435456) >> 29;
		acc = '0;
		if (i == 0) begin
			acc = PI_Q60;
		end else begin
			for (int k = 0; k < 32; k++) begin
				span = i * (2 * k + 1);
				if (span <= 62) begin
					term = udiv(64'd1 << (62 - span), 64'(2 * k + 1));
					if ((k & 1) != 0) begin
						acc = acc - term;
					end else begin
						acc = acc + term;
					end
				end
			end
		end
		return 32'(udiv(acc + (two_pi >> 1), two_pi));
	endfunction

endpackage

// ----- hdl/hvd_rotate.sv -----
// ---------------------------------------------------------------------------
// hvd_rotate
// Degree value to binary phase (three stages), quadrant fold, then a
// pipelined rotation CORDIC giving cosine and sine in Q30.
// ---------------------------------------------------------------------------
module hvd_rotate
	import hvd_pkg::*;
#(
	parameter int STAGES = 24
) (
	input  logic                clk,
	input  logic                en,
	input  logic signed [32:0]  value,
	input  logic                full_angle,
	output logic signed [31:0]  cos_val,
	output logic signed [31:0]  sin_val
);

	// magnitude, scale and split around 2^20
	logic [32:0] mag;
	logic [39:0] num;
	logic [19:0] num_hi;
	logic [19:0] num_lo;
	logic [34:0] hi_full;
	logic [25:0] x_c;

	always_comb begin
		mag = value[32] ? 33'(-value) : 33'(value);
		num = full_angle ? ((40'(mag) << 6) + 40'd22) : ((40'(mag) << 5) + 40'd22);
		num_hi = num[39:20];
		num_lo = num[19:0];
		hi_full = 35'(num_hi) * 35'd23301;
		x_c = (26'(num_hi) << 5) - 26'(num_hi) + 26'(num_lo);
	end

	logic [25:0] x_s1;
	logic [31:0] hi_s1;
	logic        neg_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1   <= x_c;
			hi_s1  <= hi_full[31:0];
			neg_s1 <= value[32];
		end
	end

	// reciprocal multiply for the quotient by 45
	logic [52:0] prod;
	assign prod = 53'(x_s1) * 53'(RECIP45);

	logic [20:0] q1_s2;
	logic [25:0] x_s2;
	logic [31:0] hi_s2;
	logic        neg_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			q1_s2  <= prod[52:32];
			x_s2   <= x_s1;
			hi_s2  <= hi_s1;
			neg_s2 <= neg_s1;
		end
	end

	// correct the quotient by one and apply the sign
	logic [26:0] rem45;
	logic [20:0] quot;
	logic [31:0] mag_phase;
	logic [31:0] phase_c;

	always_comb begin
		rem45 = 27'(x_s2) - 27'(q1_s2) * 27'd45;
		quot = (rem45 >= 27'd45) ? q1_s2 + 21'd1 : q1_s2;
		mag_phase = hi_s2 + 32'(quot);
		phase_c = neg_s2 ? -mag_phase : mag_phase;
	end

	logic [31:0] phase_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			phase_s3 <= phase_c;
		end
	end

	// fold into [-1/4, 1/4) turn
	logic [31:0] quarter;
	logic        fold_c;
	logic [31:0] folded;

	always_comb begin
		quarter = phase_s3 + 32'h4000_0000;
		fold_c = quarter[31];
		folded = fold_c ? phase_s3 + 32'h8000_0000 : phase_s3;
	end

	logic signed [32:0] z_s4;
	logic               fold_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			z_s4    <= 33'(signed'(folded));
			fold_s4 <= fold_c;
		end
	end

	// rotation iterations, one per stage
	logic signed [31:0] x_it [0:STAGES];
	logic signed [31:0] y_it [0:STAGES];
	logic signed [32:0] z_it [0:STAGES];
	logic               fold_it [0:STAGES];

	assign x_it[0]    = GAIN_Q30;
	assign y_it[0]    = '0;
	assign z_it[0]    = z_s4;
	assign fold_it[0] = fold_s4;

	for (genvar i = 0; i < STAGES; i++) begin : g_iter
		localparam logic signed [32:0] ATAN_I = 33'(atan_entry(i));
		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_it[i][32]) begin
					x_it[i+1] <= x_it[i] - (y_it[i] >>> i);
					y_it[i+1] <= y_it[i] + (x_it[i] >>> i);
					z_it[i+1] <= z_it[i] - ATAN_I;
				end else begin
					x_it[i+1] <= x_it[i] + (y_it[i] >>> i);
					y_it[i+1] <= y_it[i] - (x_it[i] >>> i);
					z_it[i+1] <= z_it[i] + ATAN_I;
				end
				fold_it[i+1] <= fold_it[i];
			end
		end
	end

	// undo the fold
	always_ff @(posedge clk) begin
		if (en) begin
			cos_val <= fold_it[STAGES] ? -x_it[STAGES] : x_it[STAGES];
			sin_val <= fold_it[STAGES] ? -y_it[STAGES] : y_it[STAGES];
		end
	end

endmodule

// ----- hdl/haversine_distance.sv -----
// ---------------------------------------------------------------------------
// haversine_distance
// Great circle distance between two points given in degrees, haversine
// formula on CORDIC, square root and vectoring pipelines.
// ---------------------------------------------------------------------------
// Fully pipelined: one point pair per cycle unless the output stalls.
// The depth is set by the two CORDIC pipelines (one stage per iteration) and
// the 31-step square root. A result stalled at the output freezes the whole
// pipeline, and with it the input. Coordinates out of range wrap as angles;
// distance_km is km in Q16.
module haversine_distance
	import hvd_pkg::*;
#(
	parameter int CORDIC_STAGES = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [30:0] lat_a,
	input  logic signed [31:0] lon_a,
	input  logic signed [30:0] lat_b,
	input  logic signed [31:0] lon_b,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [30:0]        distance_km
);

	localparam int LAT = 2 * CORDIC_STAGES + 43;

	logic en;
	logic vld_s [1:LAT];

	// advance unless a finished result is held at the output
	assign en       = !(vld_s[LAT] && out_stall);
	assign in_stall = !en;
	assign out_valid = vld_s[LAT];

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= LAT; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (en) begin
			vld_s[1] <= in_valid;
			for (int k = 2; k <= LAT; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	// capture the transaction
	logic signed [30:0] lat_a_s1;
	logic signed [31:0] lon_a_s1;
	logic signed [30:0] lat_b_s1;
	logic signed [31:0] lon_b_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			lat_a_s1 <= lat_a;
			lon_a_s1 <= lon_a;
			lat_b_s1 <= lat_b;
			lon_b_s1 <= lon_b;
		end
	end

	logic signed [32:0] dlat;
	logic signed [32:0] dlon;

	assign dlat = 33'(lat_b_s1) - 33'(lat_a_s1);
	assign dlon = 33'(lon_b_s1) - 33'(lon_a_s1);

	// half differences give sines, latitudes give cosines
	logic signed [31:0] sin_lat;
	logic signed [31:0] sin_lon;
	logic signed [31:0] cos_a;
	logic signed [31:0] cos_b;

	hvd_rotate #(.STAGES(CORDIC_STAGES)) u_rot_dlat (
		.clk(clk), .en(en), .value(dlat), .full_angle(1'b0),
		.cos_val(), .sin_val(sin_lat)
	);

	hvd_rotate #(.STAGES(CORDIC_STAGES)) u_rot_dlon (
		.clk(clk), .en(en), .value(dlon), .full_angle(1'b0),
		.cos_val(), .sin_val(sin_lon)
	);

	hvd_rotate #(.STAGES(CORDIC_STAGES)) u_rot_lata (
		.clk(clk), .en(en), .value(33'(lat_a_s1)), .full_angle(1'b1),
		.cos_val(cos_a), .sin_val()
	);

	hvd_rotate #(.STAGES(CORDIC_STAGES)) u_rot_latb (
		.clk(clk), .en(en), .value(33'(lat_b_s1)), .full_angle(1'b1),
		.cos_val(cos_b), .sin_val()
	);

	// Q30 product with round half up, floor shift
	function automatic logic signed [33:0] mulq(input logic signed [33:0] a,
			input logic signed [33:0] b);
		logic signed [67:0] p;
		p = 68'(a) * 68'(b) + 68'sd536870912;
		return 34'(p >>> 30);
	endfunction

	// haversine term, three stages
	logic signed [33:0] mul_ss_s1;
	logic signed [33:0] mul_cc_s1;
	logic signed [33:0] mul_oo_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			mul_ss_s1 <= mulq(34'(sin_lat), 34'(sin_lat));
			mul_cc_s1 <= mulq(34'(cos_a), 34'(cos_b));
			mul_oo_s1 <= mulq(34'(sin_lon), 34'(sin_lon));
		end
	end

	logic signed [33:0] mul_ss_s2;
	logic signed [33:0] mul_t_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			mul_ss_s2 <= mul_ss_s1;
			mul_t_s2  <= mulq(mul_cc_s1, mul_oo_s1);
		end
	end

	// clamp a to [0, 1]
	logic signed [34:0] hav_sum;
	logic [30:0]        hav_c;

	always_comb begin
		hav_sum = 35'(mul_ss_s2) + 35'(mul_t_s2);
		if (hav_sum < 35'sd0) begin
			hav_c = '0;
		end else if (hav_sum > 35'(ONE_Q30)) begin
			hav_c = ONE_Q30;
		end else begin
			hav_c = hav_sum[30:0];
		end
	end

	logic [30:0] hav_a_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			hav_a_s3 <= hav_c;
		end
	end

	// square roots of a and 1-a, one result bit per stage
	logic [61:0] sqa_rem_s  [0:SQRT_STEPS];
	logic [61:0] sqa_root_s [0:SQRT_STEPS];
	logic [61:0] sqb_rem_s  [0:SQRT_STEPS];
	logic [61:0] sqb_root_s [0:SQRT_STEPS];

	assign sqa_rem_s[0]  = 62'(hav_a_s3) << 30;
	assign sqa_root_s[0] = '0;
	assign sqb_rem_s[0]  = 62'(ONE_Q30 - hav_a_s3) << 30;
	assign sqb_root_s[0] = '0;

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
		localparam logic [61:0] BIT = 62'd1 << (60 - 2 * k);
		always_ff @(posedge clk) begin
			if (en) begin
				if (sqa_rem_s[k] >= sqa_root_s[k] + BIT) begin
					sqa_rem_s[k+1]  <= sqa_rem_s[k] - (sqa_root_s[k] + BIT);
					sqa_root_s[k+1] <= (sqa_root_s[k] >> 1) + BIT;
				end else begin
					sqa_rem_s[k+1]  <= sqa_rem_s[k];
					sqa_root_s[k+1] <= sqa_root_s[k] >> 1;
				end
				if (sqb_rem_s[k] >= sqb_root_s[k] + BIT) begin
					sqb_rem_s[k+1]  <= sqb_rem_s[k] - (sqb_root_s[k] + BIT);
					sqb_root_s[k+1] <= (sqb_root_s[k] >> 1) + BIT;
				end else begin
					sqb_rem_s[k+1]  <= sqb_rem_s[k];
					sqb_root_s[k+1] <= sqb_root_s[k] >> 1;
				end
			end
		end
	end

	// vectoring CORDIC for atan2(sqrt(a), sqrt(1-a))
	logic signed [32:0] vx_s [0:CORDIC_STAGES];
	logic signed [32:0] vy_s [0:CORDIC_STAGES];
	logic signed [33:0] vz_s [0:CORDIC_STAGES];

	assign vx_s[0] = 33'(sqb_root_s[SQRT_STEPS][30:0]);
	assign vy_s[0] = 33'(sqa_root_s[SQRT_STEPS][30:0]);
	assign vz_s[0] = '0;

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_vec
		localparam logic signed [33:0] ATAN_I = 34'(atan_entry(i));
		always_ff @(posedge clk) begin
			if (en) begin
				if (vy_s[i] > 33'sd0) begin
					vx_s[i+1] <= vx_s[i] + (vy_s[i] >>> i);
					vy_s[i+1] <= vy_s[i] - (vx_s[i] >>> i);
					vz_s[i+1] <= vz_s[i] + ATAN_I;
				end else begin
					vx_s[i+1] <= vx_s[i] - (vy_s[i] >>> i);
					vy_s[i+1] <= vy_s[i] + (vx_s[i] >>> i);
					vz_s[i+1] <= vz_s[i] - ATAN_I;
				end
			end
		end
	end

	// clamp the angle to [0, 1/4] turn
	logic [30:0] ang_c;

	always_comb begin
		if (vz_s[CORDIC_STAGES] < 34'sd0) begin
			ang_c = '0;
		end else if (vz_s[CORDIC_STAGES] > 34'(ONE_Q30)) begin
			ang_c = ONE_Q30;
		end else begin
			ang_c = vz_s[CORDIC_STAGES][30:0];
		end
	end

	logic [30:0] ang_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			ang_s1 <= ang_c;
		end
	end

	// scale by the radius in two partial products
	logic [47:0] dst_lo_s2;
	logic [47:0] dst_hi_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			dst_lo_s2 <= 48'(ang_s1) * 48'(KD_LO);
			dst_hi_s2 <= 48'(ang_s1) * 48'(KD_HI);
		end
	end

	logic [64:0] dst_sum;

	assign dst_sum = (65'(dst_hi_s2) << 17) + 65'(dst_lo_s2) + (65'd1 << 32);

	// hold the result for the output transaction
	always_ff @(posedge clk) begin
		if (en) begin
			distance_km <= dst_sum[63:33];
		end
	end

	// input is held back only by a stalled output transaction
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a held output transaction");

	// the angle never exceeds a quarter turn, so the distance stays bounded
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (distance_km <= 31'd1311709000))
		else $error("distance beyond half circumference");

endmodule

// ----- tb/tb.sv -----
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for haversine_distance: a driver and a monitor feed
// point pairs through the valid/stall channels under several idle and stall
// mixes, and every distance is compared with a CORDIC-exact prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb
	import hvd_pkg::*;
;

	localparam int STAGES = 24;
	localparam int LAT_MAX = 754974720;
	localparam int LON_MAX = 1509949440;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct {
		logic signed [30:0] la;
		logic signed [31:0] oa;
		logic signed [30:0] lb;
		logic signed [31:0] ob;
		int                 tx_pct;
		int                 rx_pct;
		bit                 drain;
	} pair_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic signed [30:0] lat_a;
	logic signed [31:0] lon_a;
	logic signed [30:0] lat_b;
	logic signed [31:0] lon_b;
	logic               out_valid;
	logic               out_stall;
	logic [30:0]        distance_km;

	pair_t       pending_pairs[$];
	logic [30:0] expected_dist[$];
	longint      atan_tbl[40];
	int          rx_pct;
	int          fails;
	int          idle_cycles;

	haversine_distance #(.CORDIC_STAGES(STAGES)) DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.lat_a(lat_a), .lon_a(lon_a), .lat_b(lat_b), .lon_b(lon_b),
		.out_valid(out_valid), .out_stall(out_stall), .distance_km(distance_km)
	);

	// clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// distance prediction
	// ------------------------------------------------------------------
	function automatic void build_atan_tbl();
		longint unsigned two_pi, acc, term;
		int span;
		two_pi = (PI_Q60 + 64'd268435456) >> 29;
		for (int i = 0; i < 40; i++) begin
			acc = 0;
			if (i == 0) begin
				acc = PI_Q60;
			end else begin
				for (int k = 0; k < 32; k++) begin
					span = i * (2 * k + 1);
					if (span <= 62) begin
						term = (64'd1 << (62 - span)) / longint'(2 * k + 1);
						if (k % 2 == 1) acc = acc - term;
						else acc = acc + term;
					end
				end
			end
			atan_tbl[i] = longint'(32'((acc + two_pi / 2) / two_pi));
		end
	endfunction

	function automatic logic [31:0] turns(input longint v, input longint mul);
		longint unsigned mag, q;
		mag = (v < 0) ? longint'(-v) : v;
		q = (mag * mul + 22) / 45;
		if (v < 0) q = -q;
		return q[31:0];
	endfunction

	function automatic void rotate(input logic [31:0] phase, output longint c,
			output longint s);
		bit     flip;
		longint x, y, z, dx, dy;
		logic [31:0] p, t;
		t = phase + 32'h40000000;
		flip = t[31];
		p = flip ? phase + 32'h80000000 : phase;
		z = longint'($signed(p));
		x = 652032874;
		y = 0;
		for (int i = 0; i < STAGES; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= atan_tbl[i];
			end else begin
				x += dx; y -= dy; z += atan_tbl[i];
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	function automatic longint qmul(input longint p, input longint q);
		return (p * q + (64'sd1 <<< 29)) >>> 30;
	endfunction

	function automatic longint unsigned root(input longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic logic [30:0] predict_distance(input logic signed [30:0] la,
			input logic signed [31:0] oa, input logic signed [30:0] lb,
			input logic signed [31:0] ob);
		longint la_l, oa_l, lb_l, ob_l, s1, s2, c1, c2, unused, hav, x, y, z, dx, dy;
		longint unsigned ra, rb, kd, dist_v;
		la_l = la; oa_l = oa; lb_l = lb; ob_l = ob;
		rotate(turns(lb_l - la_l, 32), unused, s1);
		rotate(turns(ob_l - oa_l, 32), unused, s2);
		rotate(turns(la_l, 64), c1, unused);
		rotate(turns(lb_l, 64), c2, unused);
		hav = qmul(s1, s1) + qmul(qmul(c1, c2), qmul(s2, s2));
		// clamp so the roots never see a negative argument
		if (hav < 0) hav = 0;
		if (hav > 64'sd1073741824) hav = 64'sd1073741824;
		ra = root(longint'(hav) << 30);
		rb = root((64'd1073741824 - hav) << 30);
		// vectoring CORDIC for the central angle
		x = rb; y = ra; z = 0;
		for (int i = 0; i < STAGES; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x += dx; y -= dy; z += atan_tbl[i];
			end else begin
				x -= dx; y += dy; z -= atan_tbl[i];
			end
		end
		if (z < 0) z = 0;
		if (z > 64'sd1073741824) z = 64'sd1073741824;
		kd = ((PI_Q60 >> 20) * 64'd25484 + 64'd4194304) >> 23;
		dist_v = (longint'(z) * kd + (64'd1 << 32)) >> 33;
		return dist_v[30:0];
	endfunction

	// ------------------------------------------------------------------
	// driver: present queued pairs, hold while stalled
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		bit    free, go;
		pair_t it;
		if (!arst_n) begin
			in_valid <= 1'b0;
			lat_a <= '0;
			lon_a <= '0;
			lat_b <= '0;
			lon_b <= '0;
			rx_pct <= 0;
		end else begin
			if (in_valid && !in_stall)
				expected_dist.insert(expected_dist.size(),
					predict_distance(lat_a, lon_a, lat_b, lon_b));
			free = !in_valid || !in_stall;
			if (free) begin
				go = 1'b0;
				if (pending_pairs.size() > 0) begin
					go = $urandom_range(99) >= pending_pairs[0].tx_pct;
					// drain point: wait until every distance is back
					if (pending_pairs[0].drain && expected_dist.size() > 0)
						go = 1'b0;
				end
				if (go) begin
					it = pending_pairs.pop_front();
					lat_a <= it.la;
					lon_a <= it.oa;
					lat_b <= it.lb;
					lon_b <= it.ob;
					rx_pct <= it.rx_pct;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// monitor: check each distance, stall at random, watchdog
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		logic [30:0] want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			idle_cycles <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_dist.size() == 0) begin
					$error("distance_km: no transaction expected, actual %0d", distance_km);
					fails++;
				end else begin
					want = expected_dist.pop_front();
					if (distance_km !== want) begin
						$error("distance_km: expected %0d, actual %0d", want, distance_km);
						fails++;
					end
				end
			end
			out_stall <= $urandom_range(99) < rx_pct;
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	function automatic longint span_rand(input longint mag);
		return longint'($urandom_range(0, 32'(2 * mag))) - mag;
	endfunction

	task automatic add_pair(input longint la, input longint oa, input longint lb,
			input longint ob, input int tx, input int rx, input bit drain);
		pair_t it;
		it.la = la[30:0];
		it.oa = oa[31:0];
		it.lb = lb[30:0];
		it.ob = ob[31:0];
		it.tx_pct = tx;
		it.rx_pct = rx;
		it.drain = drain;
		pending_pairs.insert(pending_pairs.size(), it);
	endtask

	task automatic add_random(input int tx, input int rx, input bit drain);
		longint la, oa, lb, ob;
		int pick;
		pick = $urandom_range(99);
		la = span_rand(LAT_MAX);
		oa = span_rand(LON_MAX);
		lb = span_rand(LAT_MAX);
		ob = span_rand(LON_MAX);
		if (pick < 20) begin
			// full field width, out of range angles wrap
			la = longint'($signed(31'($urandom)));
			oa = longint'($signed($urandom));
			lb = longint'($signed(31'($urandom)));
			ob = longint'($signed($urandom));
		end else if (pick < 28) begin
			// identical or nearly identical points
			lb = la + $urandom_range(0, 64) - 32;
			ob = oa + $urandom_range(0, 64) - 32;
		end else if (pick < 36) begin
			// near antipodal
			lb = -la + $urandom_range(0, 64) - 32;
			ob = (oa > 0) ? oa - LON_MAX : oa + LON_MAX;
		end
		add_pair(la, oa, lb, ob, tx, rx, drain);
	endtask

	initial begin
		int tx_set[4];
		int rx_set[4];
		clk = 1'b0;
		arst_n = 1'b0;
		fails = 0;
		build_atan_tbl();
		tx_set = '{0, 76, 0, 14};
		rx_set = '{0, 0, 76, 14};

		// directed: extremes, identical, antipodal, wrap, full width
		add_pair(0, 0, 0, 0, 0, 0, 0);
		add_pair(LAT_MAX, LON_MAX, LAT_MAX, LON_MAX, 0, 0, 0);
		add_pair(-LAT_MAX, -LON_MAX, -LAT_MAX, -LON_MAX, 0, 0, 0);
		add_pair(LAT_MAX, 0, -LAT_MAX, 0, 0, 0, 0);
		add_pair(0, 0, 0, LON_MAX, 0, 0, 0);
		add_pair(0, -LON_MAX, 0, LON_MAX, 0, 0, 0);
		add_pair(0, 0, 0, 1, 0, 0, 0);
		add_pair(0, 0, 1, 0, 0, 0, 0);
		add_pair(LAT_MAX, -LON_MAX, -LAT_MAX, LON_MAX, 0, 0, 0);
		add_pair(-1073741824, -2147483648, 1073741823, 2147483647, 0, 0, 0);
		add_pair(1073741823, 2147483647, -1073741824, -2147483648, 0, 0, 0);
		add_pair(-1073741824, 2147483647, -1073741824, 2147483647, 0, 0, 0);
		add_pair(-1, -1, -1, -1, 0, 0, 0);
		add_pair(377487360, 754974720, -377487360, -754974720, 0, 0, 0);
		add_pair(430000000, 20000000, 425000000, 21000000, 0, 0, 0);
		add_pair(0, 0, 0, 1509949439, 0, 0, 0);
		add_pair(LAT_MAX, 123456789, LAT_MAX, -987654321, 0, 0, 0);
		add_pair(-LAT_MAX, 5, LAT_MAX, 5, 0, 0, 0);

		// random phases, each opening once the pipeline is empty
		for (int ph = 0; ph < 8; ph++) begin
			for (int n = 0; n < 244; n++)
				add_random(tx_set[ph % 4], rx_set[ph % 4], n == 0);
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		wait (pending_pairs.size() == 0);
		@(posedge clk);
		wait (!in_valid && expected_dist.size() == 0);
		repeat (2 * STAGES + 60) @(posedge clk);
		if (fails == 0 && expected_dist.size() == 0 && !out_valid)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/hvd_pkg.sv
hdl/hvd_rotate.sv
hdl/haversine_distance.sv
tb/tb.sv
